@@ src/wud_pkg.sv @@
`timescale 1ns / 1ps

package wud_pkg;

   localparam int WORD_W = 64;

   typedef struct packed {
      logic [WORD_W-1:0] dividend_word;
      logic [WORD_W-1:0] divisor_word;
      logic              last_word;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] quotient_word;
      logic [WORD_W-1:0] remainder_word;
      logic              divide_by_zero;
      logic              last_result;
   } rsp_type;

   // One operand word pair as classified by the front end.
   typedef struct packed {
      req_type payload;
      logic    store;    // word lands in the operand registers
      logic    first;    // first word of a run: clear the upper words
   } op_entry_type;

endpackage

@@ src/wide_unsigned_divider.sv @@
`timescale 1ns / 1ps

// Unsigned divider for WORDS*64-bit operands. Send the dividend and divisor
// one 64-bit word pair per transfer, least significant first, and mark the
// final pair with last_word; words not sent count as zero and pairs beyond
// WORDS are ignored. The block answers with WORDS transfers, least
// significant first, each carrying one quotient word and one remainder word;
// last_result marks the top word. A zero divisor sets divide_by_zero, gives
// an all-ones quotient and returns the dividend as remainder. Operand words
// enter at one per cycle unless req_stall holds them while the two-entry
// queue is full, so up to two words of the next operands can wait while a
// division is still running. A division loads the queued words, then finds
// one quotient bit per cycle through a single full-width subtractor, then
// sends its result transfers, which rsp_stall can hold.
module wide_unsigned_divider import wud_pkg::*; #(
   parameter int WORDS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic         push_valid;
   op_entry_type push_entry;
   logic         queue_full;
   logic         pop;
   logic         not_empty;
   op_entry_type pop_entry;

   wud_front #(
      .WORDS(WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   wud_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_entry (pop_entry)
   );

   wud_back #(
      .WORDS(WORDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

@@ src/wud_front.sv @@
`timescale 1ns / 1ps

module wud_front import wud_pkg::*; #(
   parameter int WORDS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_payload,
   input  logic         queue_full,
   output logic         push_valid,
   output op_entry_type push_entry
);

   localparam int CNT_W = $clog2(WORDS + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             accept;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   assign push_entry.payload = req_payload;
   assign push_entry.store   = (count_ff < CNT_W'(WORDS));
   assign push_entry.first   = (count_ff == '0);

   // Drop surplus words unless they carry the last mark.
   assign push_valid = accept & (push_entry.store | req_payload.last_word);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_payload.last_word) begin
            count_in = '0;
         end else if (push_entry.store) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ src/wud_queue.sv @@
`timescale 1ns / 1ps

module wud_queue import wud_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  op_entry_type push_entry,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output op_entry_type pop_entry
);

   op_entry_type slot_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push;
   logic         do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop & not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ src/wud_back.sv @@
`timescale 1ns / 1ps

module wud_back import wud_pkg::*; #(
   parameter int WORDS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         not_empty,
   input  op_entry_type pop_entry,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int W     = WORDS * WORD_W;
   localparam int BIT_W = $clog2(W);
   localparam int CNT_W = $clog2(WORDS + 1);
   localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [1:0] {
      LOAD,
      RUN,
      EMIT
   } state_type;

   state_type        state_ff;
   logic [W-1:0]     dq_ff;        // dividend, becomes quotient bit by bit
   logic [W-1:0]     divisor_ff;
   logic [W-1:0]     rem_ff;
   logic [CNT_W-1:0] ptr_ff;
   logic [BIT_W-1:0] bit_ff;
   logic [IDX_W-1:0] emit_ff;
   logic             dz_ff;

   logic [W-1:0]     dq_in;
   logic [W-1:0]     divisor_in;
   logic [W:0]       shifted;
   logic [W+1:0]     diff;
   logic             borrow;

   // Place the incoming word pair; the first word of a run zeroes the rest.
   always_comb begin
      dq_in      = dq_ff;
      divisor_in = divisor_ff;
      for (int k = 0; k < WORDS; k++) begin
         if (pop_entry.first) begin
            dq_in[k*WORD_W +: WORD_W] =
               (k == 0) ? pop_entry.payload.dividend_word : '0;
            divisor_in[k*WORD_W +: WORD_W] =
               (k == 0) ? pop_entry.payload.divisor_word : '0;
         end else if (ptr_ff == CNT_W'(k)) begin
            dq_in[k*WORD_W +: WORD_W]      = pop_entry.payload.dividend_word;
            divisor_in[k*WORD_W +: WORD_W] = pop_entry.payload.divisor_word;
         end
      end
   end

   // One restoring step: shift in the next dividend bit, try the subtract.
   assign shifted = {rem_ff, dq_ff[W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor_ff};
   assign borrow  = diff[W+1];

   assign pop       = (state_ff == LOAD) & not_empty;
   assign rsp_valid = (state_ff == EMIT);

   assign rsp_payload.quotient_word  = dq_ff[WORD_W-1:0];
   assign rsp_payload.remainder_word = rem_ff[WORD_W-1:0];
   assign rsp_payload.divide_by_zero = dz_ff;
   assign rsp_payload.last_result    = (emit_ff == IDX_W'(WORDS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
         ptr_ff   <= '0;
         bit_ff   <= '0;
         emit_ff  <= '0;
         dz_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            LOAD: begin
               if (not_empty) begin
                  if (pop_entry.store) begin
                     dq_ff      <= dq_in;
                     divisor_ff <= divisor_in;
                     ptr_ff     <= pop_entry.first ? CNT_W'(1) : ptr_ff + CNT_W'(1);
                  end
                  if (pop_entry.payload.last_word) begin
                     rem_ff   <= '0;
                     bit_ff   <= BIT_W'(W - 1);
                     state_ff <= RUN;
                  end
               end
            end
            RUN: begin
               // A zero divisor runs through as well: all-ones quotient,
               // remainder equal to the dividend.
               dz_ff <= ~|divisor_ff;
               dq_ff <= {dq_ff[W-2:0], ~borrow};
               if (!borrow) begin
                  rem_ff <= diff[W-1:0];
               end else begin
                  rem_ff <= shifted[W-1:0];
               end
               if (bit_ff == '0) begin
                  emit_ff  <= '0;
                  state_ff <= EMIT;
               end else begin
                  bit_ff <= bit_ff - BIT_W'(1);
               end
            end
            EMIT: begin
               if (!rsp_stall) begin
                  dq_ff   <= dq_ff >> WORD_W;
                  rem_ff  <= rem_ff >> WORD_W;
                  emit_ff <= emit_ff + IDX_W'(1);
                  if (rsp_payload.last_result) begin
                     state_ff <= LOAD;
                  end
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import wud_pkg::*;

   localparam int WORDS = 4;
   localparam int WIDE = WORDS * WORD_W;
   localparam int RANDOM_WORDS = 286;
   localparam int DRAIN_CYCLES = WORDS * 64 + 2 * WORDS + 16;

   typedef struct packed {
      req_type         item;
      logic            known;
      logic [WIDE-1:0] quotient;
      logic [WIDE-1:0] remainder;
      logic            by_zero;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // operand registers as seen by the divider, plus the count of words held
   logic [WORD_W-1:0] dividend_words [WORDS];
   logic [WORD_W-1:0] divisor_words [WORDS];
   int                words_held = 0;

   rsp_type          awaited_results [$];
   directed_row_type directed_rows [$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   bit               failed = 1'b0;

   wide_unsigned_divider #(
      .WORDS(WORDS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Store one word pair; on the last mark, divide and queue the quotient and
   // remainder words. A row with known values overrides the computed answer.
   task automatic divide_operands(input req_type item, input bit known,
                                  input logic [WIDE-1:0] typed_quotient,
                                  input logic [WIDE-1:0] typed_remainder,
                                  input bit typed_by_zero);
      logic [WIDE-1:0] dividend;
      logic [WIDE-1:0] divisor;
      logic [WIDE-1:0] quotient;
      logic [WIDE-1:0] remainder;
      bit              by_zero;
      rsp_type         result;
      if (words_held < WORDS) begin
         dividend_words[words_held] = item.dividend_word;
         divisor_words[words_held] = item.divisor_word;
         words_held++;
      end
      if (!item.last_word)
         return;
      for (int k = words_held; k < WORDS; k++) begin
         dividend_words[k] = '0;
         divisor_words[k] = '0;
      end
      words_held = 0;
      for (int k = 0; k < WORDS; k++) begin
         dividend[k*WORD_W +: WORD_W] = dividend_words[k];
         divisor[k*WORD_W +: WORD_W] = divisor_words[k];
      end
      by_zero = (divisor == '0);
      if (known) begin
         quotient = typed_quotient;
         remainder = typed_remainder;
         by_zero = typed_by_zero;
      end else if (by_zero) begin
         quotient = '1;
         remainder = dividend;
      end else begin
         quotient = dividend / divisor;
         remainder = dividend % divisor;
      end
      for (int k = 0; k < WORDS; k++) begin
         result.quotient_word = quotient[k*WORD_W +: WORD_W];
         result.remainder_word = remainder[k*WORD_W +: WORD_W];
         result.divide_by_zero = by_zero;
         result.last_result = (k == WORDS - 1);
         awaited_results.push_back(result);
      end
   endtask

   task automatic send_word(input req_type item, input bit known,
                            input logic [WIDE-1:0] typed_quotient,
                            input logic [WIDE-1:0] typed_remainder,
                            input bit typed_by_zero);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      // hold until the transfer goes through
      do @(posedge clock); while (req_stall);
      divide_operands(item, known, typed_quotient, typed_remainder, typed_by_zero);
   endtask

   function automatic void add_row(input logic [WORD_W-1:0] dividend_word,
                                   input logic [WORD_W-1:0] divisor_word,
                                   input bit last, input bit known,
                                   input logic [WIDE-1:0] quotient,
                                   input logic [WIDE-1:0] remainder,
                                   input bit by_zero);
      directed_row_type row;
      row.item.dividend_word = dividend_word;
      row.item.divisor_word = divisor_word;
      row.item.last_word = last;
      row.known = known;
      row.quotient = quotient;
      row.remainder = remainder;
      row.by_zero = by_zero;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return 64'($urandom_range(255));
         3: return 64'(1) << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $display("%0t: unexpected result transfer %h", $time, got);
         failed = 1'b1;
         return;
      end
      want = awaited_results.pop_front();
      if (got.quotient_word !== want.quotient_word) begin
         $display("%0t: quotient_word expected %h got %h", $time,
                  want.quotient_word, got.quotient_word);
         failed = 1'b1;
      end
      if (got.remainder_word !== want.remainder_word) begin
         $display("%0t: remainder_word expected %h got %h", $time,
                  want.remainder_word, got.remainder_word);
         failed = 1'b1;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
         $display("%0t: divide_by_zero expected %b got %b", $time,
                  want.divide_by_zero, got.divide_by_zero);
         failed = 1'b1;
      end
      if (got.last_result !== want.last_result) begin
         $display("%0t: last_result expected %b got %b", $time,
                  want.last_result, got.last_result);
         failed = 1'b1;
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            check_result(rsp_payload);
         rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      req_type item;
      int      loaded;
      int      run_len;
      int      divisor_len;

      // single word runs with answers readable at a glance
      add_row(100, 7, 1, 1, 14, 2, 0);
      add_row(5, 0, 1, 1, '1, 5, 1);
      add_row('1, '1, 1, 1, 1, 0, 0);
      add_row('1, 1, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
      add_row(0, 3, 1, 1, 0, 0, 0);
      add_row(3, 5, 1, 1, 0, 3, 0);
      add_row(0, 0, 1, 1, '1, 0, 1);
      // full width dividend over a divisor of one
      add_row('1, 1, 0, 0, 0, 0, 0);
      add_row('1, 0, 0, 0, 0, 0, 0);
      add_row('1, 0, 0, 0, 0, 0, 0);
      add_row('1, 0, 1, 1, '1, 0, 0);
      // extra words past the top are dropped
      add_row(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0001_0003, 0, 0, 0, 0, 0);
      add_row(64'hFEDC_BA98_7654_3210, 64'h0000_0000_0000_0007, 0, 0, 0, 0, 0);
      add_row(64'h8000_0000_0000_0001, 0, 0, 0, 0, 0, 0);
      add_row(64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0);
      add_row('1, '1, 0, 0, 0, 0, 0);
      add_row('1, '1, 1, 0, 0, 0, 0);
      // zero divisor over two words returns the dividend
      add_row(64'h1234, 0, 0, 0, 0, 0, 0);
      add_row(64'hABCD, 0, 1, 1, '1, {64'h0, 64'h0, 64'hABCD, 64'h1234}, 1);
      // divisor only in the top bit
      add_row('1, 0, 0, 0, 0, 0, 0);
      add_row('1, 0, 0, 0, 0, 0, 0);
      add_row('1, 0, 0, 0, 0, 0, 0);
      add_row('1, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 0);
      add_row('1, 2, 1, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n])
         send_word(directed_rows[n].item, directed_rows[n].known, directed_rows[n].quotient,
                   directed_rows[n].remainder, directed_rows[n].by_zero);

      loaded = 0;
      while (loaded < RANDOM_WORDS) begin
         case ((loaded * 4) / RANDOM_WORDS)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 56;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 56;
            end
            default: begin
               send_idle_pct = 16;
               recv_stall_pct = 16;
            end
         endcase
         if ($urandom_range(99) < 85)
            run_len = $urandom_range(WORDS, 1);
         else
            run_len = $urandom_range(WORDS + 3, WORDS + 1);
         divisor_len = $urandom_range(run_len, 1);
         for (int i = 0; i < run_len; i++) begin
            item.dividend_word = pick_word();
            item.divisor_word = (i < divisor_len) ? pick_word() : '0;
            item.last_word = (i == run_len - 1);
            send_word(item, 1'b0, '0, '0, 1'b0);
            loaded++;
         end
      end
      req_valid <= 1'b0;

      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
